// ===== rtl/core/tlp_pkg.sv =====
`default_nettype none

package tlp_pkg;

  // Line buffer: holds at most LINE_DEPTH-1 characters
  localparam int LINE_DEPTH = 64;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // Subnegotiation byte counter saturates at SUB_DEPTH-1
  localparam int SUB_DEPTH = 64;
  localparam int SUB_CW    = $clog2(SUB_DEPTH);

  // NAWS payload length in bytes
  localparam int NAWS_LEN = 4;

  // Telnet command octets
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_EL   = 8'd248;
  localparam logic [7:0] B_EC   = 8'd247;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_NONE = 8'd0;

  localparam logic [7:0] OPT_NAWS = 8'd31;

  // Line editing characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Window size after reset
  localparam logic [15:0] COLS_RESET = 16'd80;
  localparam logic [15:0] ROWS_RESET = 16'd25;

  typedef enum logic [2:0] {
    KIND_CHAR     = 3'd0,
    KIND_END      = 3'd1,
    KIND_WIN      = 3'd2,
    KIND_BAD_NAWS = 3'd3,
    KIND_CLOSED   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND,
    ST_END
  } state_t;

  // Datapath -> controller
  typedef struct packed {
    logic byte_valid;
    logic out_free;
    logic line_start;
    logic idx_last;
  } dp_status_t;

  // Controller -> datapath
  typedef struct packed {
    logic process;
    logic fetch;
    logic send_char;
    logic send_end;
  } dp_cmd_t;

  // Commands that are followed by an option byte
  function automatic logic takes_option(input logic [7:0] c);
    return (c == B_DO) || (c == B_DONT) || (c == B_SB) || (c == B_WILL) || (c == B_WONT);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tlp_ram.sv =====
`default_nettype none

module tlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlp_dp.sv =====
`default_nettype none

module tlp_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         byte_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              kind,
  output logic [7:0]              char_value,
  output logic [15:0]             window_width,
  output logic [15:0]             window_height,
  output logic                    last,
  input  wire tlp_pkg::dp_cmd_t   cmd,
  output tlp_pkg::dp_status_t     status
);

  // Input holding register
  logic [7:0] byte_reg;
  logic       byte_valid;

  // Parser state
  logic [7:0]                  command_state;
  logic [7:0]                  option_code;
  logic                        sub_active;
  logic [7:0]                  sub_store [tlp_pkg::NAWS_LEN];
  logic [tlp_pkg::SUB_CW-1:0]  sub_count;
  logic [15:0]                 cols_reg;
  logic [15:0]                 rows_reg;
  logic [tlp_pkg::LINE_AW-1:0] line_count;
  logic                        closed_flag;
  logic [tlp_pkg::LINE_AW-1:0] idx;

  // Output register
  tlp_pkg::kind_t out_kind;
  logic [7:0]     out_char;
  logic [15:0]    out_w;
  logic [15:0]    out_h;
  logic           out_last;

  // Step results
  logic                        line_en;
  logic                        sub_en;
  logic                        run_en;
  logic [7:0]                  cmd_code;
  logic [7:0]                  command_state_next;
  logic [7:0]                  option_code_next;
  logic                        sub_active_next;
  logic [tlp_pkg::SUB_CW-1:0]  sub_count_next;
  logic                        sub_wr;
  logic [tlp_pkg::LINE_AW-1:0] line_count_next;
  logic                        closed_next;
  logic                        line_wr;
  logic                        line_start;
  logic                        naws_load;
  logic                        res_valid;
  tlp_pkg::kind_t              res_kind;
  logic [15:0]                 naws_w;
  logic [15:0]                 naws_h;
  logic                        out_free;
  logic [7:0]                  rd_data;

  assign naws_w = {sub_store[0], sub_store[1]};
  assign naws_h = {sub_store[2], sub_store[3]};

  // Route the held byte: line editor, subnegotiation data or command
  always_comb begin
    line_en            = 1'b0;
    sub_en             = 1'b0;
    run_en             = 1'b0;
    cmd_code           = command_state;
    command_state_next = command_state;
    option_code_next   = option_code;
    if (!closed_flag) begin
      if (command_state == tlp_pkg::B_NONE) begin
        if (byte_reg == tlp_pkg::B_IAC) begin
          command_state_next = tlp_pkg::B_IAC;
        end else if (sub_active) begin
          sub_en = 1'b1;
        end else begin
          line_en = 1'b1;
        end
      end else if (command_state == tlp_pkg::B_IAC) begin
        if (byte_reg == tlp_pkg::B_IAC) begin
          if (sub_active) begin
            sub_en = 1'b1;
          end else begin
            line_en = 1'b1;
          end
          command_state_next = tlp_pkg::B_NONE;
        end else if (tlp_pkg::takes_option(byte_reg)) begin
          command_state_next = byte_reg;
        end else begin
          run_en             = 1'b1;
          cmd_code           = byte_reg;
          command_state_next = tlp_pkg::B_NONE;
        end
      end else if (tlp_pkg::takes_option(command_state)) begin
        option_code_next   = byte_reg;
        run_en             = 1'b1;
        command_state_next = tlp_pkg::B_NONE;
      end else begin
        command_state_next = tlp_pkg::B_NONE;
      end
    end
  end

  // Effects of line editing, commands and subnegotiation data
  always_comb begin
    sub_active_next = sub_active;
    sub_count_next  = sub_count;
    sub_wr          = 1'b0;
    line_count_next = line_count;
    closed_next     = closed_flag;
    line_wr         = 1'b0;
    line_start      = 1'b0;
    naws_load       = 1'b0;
    res_valid       = 1'b0;
    res_kind        = tlp_pkg::KIND_END;

    if (line_en) begin
      if (byte_reg == tlp_pkg::CH_BS || byte_reg == tlp_pkg::CH_DEL) begin
        if (line_count != '0) begin
          line_count_next = line_count - 1'b1;
        end
      end else if (byte_reg == tlp_pkg::CH_LF) begin
        if (line_count == '0) begin
          res_valid = 1'b1;
          res_kind  = tlp_pkg::KIND_END;
        end else begin
          line_start = 1'b1;
        end
      end else if (line_count >= tlp_pkg::LINE_AW'(tlp_pkg::LINE_DEPTH - 1)) begin
        closed_next = 1'b1;
        res_valid   = 1'b1;
        res_kind    = tlp_pkg::KIND_CLOSED;
      end else if (byte_reg >= tlp_pkg::CH_PRINT_LO && byte_reg <= tlp_pkg::CH_PRINT_HI) begin
        line_wr         = 1'b1;
        line_count_next = line_count + 1'b1;
      end
    end

    if (run_en) begin
      case (cmd_code)
        tlp_pkg::B_EC: begin
          if (line_count != '0) begin
            line_count_next = line_count - 1'b1;
          end
        end
        tlp_pkg::B_EL: begin
          line_count_next = '0;
        end
        tlp_pkg::B_SB: begin
          sub_active_next = 1'b1;
          sub_count_next  = '0;
        end
        tlp_pkg::B_SE: begin
          if (option_code == tlp_pkg::OPT_NAWS) begin
            res_valid = 1'b1;
            if (sub_count == tlp_pkg::SUB_CW'(tlp_pkg::NAWS_LEN)) begin
              naws_load = 1'b1;
              res_kind  = tlp_pkg::KIND_WIN;
            end else begin
              res_kind  = tlp_pkg::KIND_BAD_NAWS;
            end
          end
          sub_active_next = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Count saturates; only the first bytes are kept
    if (sub_en && sub_count < tlp_pkg::SUB_CW'(tlp_pkg::SUB_DEPTH - 1)) begin
      sub_wr         = sub_count < tlp_pkg::SUB_CW'(tlp_pkg::NAWS_LEN);
      sub_count_next = sub_count + 1'b1;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = !byte_valid || cmd.process;

  assign status.byte_valid = byte_valid;
  assign status.out_free   = out_free;
  assign status.line_start = line_start;
  assign status.idx_last   = (tlp_pkg::LINE_AW'(idx + 1'b1) == line_count);

  // Input holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (cmd.process) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= byte_value;
    end
  end

  // Parser state update
  always_ff @(posedge clk) begin
    if (rst) begin
      command_state <= tlp_pkg::B_NONE;
      option_code   <= '0;
      sub_active    <= 1'b0;
      sub_count     <= '0;
      cols_reg      <= tlp_pkg::COLS_RESET;
      rows_reg      <= tlp_pkg::ROWS_RESET;
      line_count    <= '0;
      closed_flag   <= 1'b0;
      idx           <= '0;
    end else if (cmd.process) begin
      command_state <= command_state_next;
      option_code   <= option_code_next;
      sub_active    <= sub_active_next;
      sub_count     <= sub_count_next;
      line_count    <= line_count_next;
      closed_flag   <= closed_next;
      idx           <= '0;
      if (naws_load) begin
        cols_reg <= naws_w;
        rows_reg <= naws_h;
      end
    end else if (cmd.send_char) begin
      idx <= idx + 1'b1;
    end else if (cmd.send_end) begin
      line_count <= '0;
    end
  end

  // Subnegotiation data bytes
  always_ff @(posedge clk) begin
    if (cmd.process && sub_wr) begin
      sub_store[sub_count[1:0]] <= byte_reg;
    end
  end

  // Line buffer
  tlp_ram #(
    .WIDTH (8),
    .DEPTH (tlp_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (cmd.process && line_wr),
    .waddr (line_count),
    .wdata (byte_reg),
    .re    (cmd.fetch),
    .raddr (idx),
    .rdata (rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.process && res_valid) || cmd.send_char || cmd.send_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_char) begin
      out_kind <= tlp_pkg::KIND_CHAR;
      out_char <= rd_data;
      out_w    <= '0;
      out_h    <= '0;
      out_last <= 1'b0;
    end else if (cmd.send_end) begin
      out_kind <= tlp_pkg::KIND_END;
      out_char <= '0;
      out_w    <= '0;
      out_h    <= '0;
      out_last <= 1'b1;
    end else if (cmd.process && res_valid) begin
      out_kind <= res_kind;
      out_char <= '0;
      out_w    <= naws_load ? naws_w : 16'd0;
      out_h    <= naws_load ? naws_h : 16'd0;
      out_last <= 1'b1;
    end
  end

  assign kind          = out_kind;
  assign char_value    = out_char;
  assign window_width  = out_w;
  assign window_height = out_h;
  assign last          = out_last;

endmodule

`default_nettype wire

// ===== rtl/core/tlp_ctrl.sv =====
`default_nettype none

module tlp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tlp_pkg::dp_status_t status,
  output tlp_pkg::dp_cmd_t         cmd
);

  tlp_pkg::state_t state;
  tlp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: idle parsing, then read/send loop over the line, then end marker
  always_comb begin
    state_next = state;
    case (state)
      tlp_pkg::ST_IDLE: begin
        if (status.byte_valid && status.out_free && status.line_start) begin
          state_next = tlp_pkg::ST_READ;
        end
      end
      tlp_pkg::ST_READ: begin
        state_next = tlp_pkg::ST_SEND;
      end
      tlp_pkg::ST_SEND: begin
        if (status.out_free) begin
          state_next = status.idx_last ? tlp_pkg::ST_END : tlp_pkg::ST_READ;
        end
      end
      tlp_pkg::ST_END: begin
        if (status.out_free) begin
          state_next = tlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tlp_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      tlp_pkg::ST_IDLE: cmd.process   = status.byte_valid && status.out_free;
      tlp_pkg::ST_READ: cmd.fetch     = 1'b1;
      tlp_pkg::ST_SEND: cmd.send_char = status.out_free;
      tlp_pkg::ST_END:  cmd.send_end  = status.out_free;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/telnet_receive_line_parser_top.sv =====
`default_nettype none
// A result passes through the byte holding register, then the output register.
// Throughput: one byte per cycle while results are taken; a stalled result holds the
// parser, and once the one-byte holding register is full, input ready drops.
// A line feed streams its line out, each character as a RAM read, then a transfer,
// followed by an end marker; no byte is parsed meanwhile.
// Reset (rst, synchronous) clears parser state, sets window size to 80x25, empties outputs.

module telnet_receive_line_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [7:0]       char_value,
  output logic [15:0]      window_width,
  output logic [15:0]      window_height,
  output logic             last
);

  tlp_pkg::dp_cmd_t    cmd;
  tlp_pkg::dp_status_t status;

  tlp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  tlp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .byte_value    (byte_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .char_value    (char_value),
    .window_width  (window_width),
    .window_height (window_height),
    .last          (last),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tlp_checker.sv =====
`default_nettype none

module tlp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  kind,
  input wire logic [7:0]  char_value,
  input wire logic [15:0] window_width,
  input wire logic [15:0] window_height,
  input wire logic        last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_value)
      && $stable(window_width) && $stable(window_height) && $stable(last))
    else $error("result changed while stalled");

  // Character field only carries data on line characters
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != tlp_pkg::KIND_CHAR |-> char_value == 8'd0)
    else $error("char_value nonzero outside a line character");

  // Window fields only carry data on a window size result
  a_win_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != tlp_pkg::KIND_WIN |-> window_width == 16'd0 && window_height == 16'd0)
    else $error("window fields nonzero outside a window size result");

  // Line characters are never last; every other result closes its byte
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind != tlp_pkg::KIND_CHAR)))
    else $error("last flag does not match kind");

  // Output is empty right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind telnet_receive_line_parser_top tlp_checker u_tlp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .char_value    (char_value),
  .window_width  (window_width),
  .window_height (window_height),
  .last          (last)
);

`default_nettype wire
